[hdl/kmrr_pkg.sv]
package kmrr_pkg;

   localparam int unsigned KEY_W = 16;
   localparam int unsigned MOUSE_W = 16;
   localparam int unsigned STICK_W = 12;
   localparam int unsigned AIM_W = 16;
   localparam int unsigned STEP_W = 8;
   localparam int unsigned LIMIT_W = 10;
   localparam int unsigned MLIM_W = 15;
   localparam int unsigned GAIN_W = 16;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 16;

   // key bit positions
   localparam int unsigned KEY_W_BIT = 0;
   localparam int unsigned KEY_S_BIT = 1;
   localparam int unsigned KEY_A_BIT = 2;
   localparam int unsigned KEY_D_BIT = 3;
   localparam int unsigned KEY_SHIFT_BIT = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_FAST_STEP = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FAST_LIMIT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SLOW_STEP = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SLOW_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MOUSE_X_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MOUSE_Y_LIMIT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MOUSE_X_GAIN = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_MOUSE_Y_GAIN = 3'd7;

   // reset values
   localparam logic [STEP_W-1:0] RST_FAST_STEP = 8'd50;
   localparam logic [LIMIT_W-1:0] RST_FAST_LIMIT = 10'd660;
   localparam logic [STEP_W-1:0] RST_SLOW_STEP = 8'd16;
   localparam logic [LIMIT_W-1:0] RST_SLOW_LIMIT = 10'd360;
   localparam logic [MLIM_W-1:0] RST_MOUSE_LIMIT = 15'd5000;
   localparam logic [GAIN_W-1:0] RST_MOUSE_GAIN = 16'd52429;
   localparam logic [STEP_W-1:0] RST_STEP_IN_USE = 8'd10;
   localparam logic [LIMIT_W-1:0] RST_LIMIT_IN_USE = 10'd660;

   typedef struct packed {
      logic [KEY_W-1:0] key_bits;
      logic signed [MOUSE_W-1:0] mouse_dx;
      logic signed [MOUSE_W-1:0] mouse_dy;
      logic keyboard_active;
   } req_type;

   typedef struct packed {
      logic signed [STICK_W-1:0] forward_stick;
      logic signed [STICK_W-1:0] side_stick;
      logic signed [AIM_W-1:0] aim_x;
      logic signed [AIM_W-1:0] aim_y;
   } rsp_type;

endpackage

[hdl/key_mouse_to_ramped_rocker.sv]
// A request passes through the input register (s1) and then the result register to rsp_valid.
// Throughput: one transaction per cycle while rsp_ready is high; stick levels are read and
// updated in the single logic stage between the two registers, so frames chain without gaps.
// Reset (synchronous, active high): both levels to zero, step/limit in use to 10/660,
// configuration registers to their defaults, both pipeline stages empty.
module key_mouse_to_ramped_rocker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  kmrr_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output kmrr_pkg::rsp_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [kmrr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [kmrr_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int unsigned LW = kmrr_pkg::STICK_W + 1;

   logic [kmrr_pkg::STEP_W-1:0] fast_step_ff, slow_step_ff, step_in_use_ff, step_in_use_in;
   logic [kmrr_pkg::LIMIT_W-1:0] fast_limit_ff, slow_limit_ff, limit_in_use_ff, limit_in_use_in;
   logic [kmrr_pkg::MLIM_W-1:0] mouse_x_limit_ff, mouse_y_limit_ff;
   logic [kmrr_pkg::GAIN_W-1:0] mouse_x_gain_ff, mouse_y_gain_ff;

   logic signed [kmrr_pkg::STICK_W-1:0] forward_level_ff, side_level_ff;
   logic signed [LW-1:0] forward_level_in, side_level_in;

   logic s1_valid_ff, s1_valid_in;
   kmrr_pkg::req_type s1_data_ff;
   logic rsp_valid_ff, rsp_valid_in;
   kmrr_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic advance;

   function automatic logic signed [LW-1:0] ramp(
      input logic signed [LW-1:0] v_in,
      input logic up,
      input logic down,
      input logic [kmrr_pkg::STEP_W-1:0] step,
      input logic [kmrr_pkg::LIMIT_W-1:0] lim
   );
      logic signed [LW-1:0] v, st, mx, mn, zero;
      begin
         zero = '0;
         v = v_in;
         st = $signed({{(LW-kmrr_pkg::STEP_W){1'b0}}, step});
         mx = $signed({{(LW-kmrr_pkg::LIMIT_W){1'b0}}, lim});
         mn = -mx;
         // pull back a level left outside the limit by a smaller limit
         if (v > mx) begin
            v = v - st;
            if (v < mx) v = mx;
         end else if (v < mn) begin
            v = v + st;
            if (v > mn) v = mn;
         end
         if (up && !down) begin
            if (v < zero) v = v + st;
            if (v < mx) begin
               v = v + st;
               if (v > mx) v = mx;
            end
         end else if (down && !up) begin
            if (v > zero) v = v - st;
            if (v > mn) begin
               v = v - st;
               if (v < mn) v = mn;
            end
         end else begin
            if (v < zero) begin
               v = v + st;
               if (v > zero) v = zero;
            end else if (v > zero) begin
               v = v - st;
               if (v < zero) v = zero;
            end
         end
         return v;
      end
   endfunction

   function automatic logic signed [kmrr_pkg::AIM_W-1:0] aim(
      input logic signed [kmrr_pkg::MOUSE_W-1:0] raw,
      input logic [kmrr_pkg::MLIM_W-1:0] lim,
      input logic [kmrr_pkg::GAIN_W-1:0] gain
   );
      logic signed [kmrr_pkg::MOUSE_W:0] x, l;
      logic [kmrr_pkg::MLIM_W-1:0] mag;
      logic [kmrr_pkg::MLIM_W+kmrr_pkg::GAIN_W-1:0] prod;
      logic [kmrr_pkg::AIM_W-1:0] sc;
      begin
         x = {raw[kmrr_pkg::MOUSE_W-1], raw};
         l = $signed({2'b00, lim});
         if (x > l) x = l;
         else if (x < -l) x = -l;
         mag = x[kmrr_pkg::MOUSE_W] ? kmrr_pkg::MLIM_W'(-x) : x[kmrr_pkg::MLIM_W-1:0];
         prod = mag * gain;
         sc = {1'b0, prod[kmrr_pkg::MLIM_W+kmrr_pkg::GAIN_W-1:kmrr_pkg::GAIN_W]};
         if (x[kmrr_pkg::MOUSE_W]) sc = -sc;
         return $signed(sc);
      end
   endfunction

   assign advance = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = s1_valid_ff;
         s1_valid_in = 1'b0;
      end
      if (req_valid && req_ready) s1_valid_in = 1'b1;
   end

   always_comb begin
      forward_level_in = ramp({forward_level_ff[kmrr_pkg::STICK_W-1], forward_level_ff},
                              s1_data_ff.key_bits[kmrr_pkg::KEY_W_BIT],
                              s1_data_ff.key_bits[kmrr_pkg::KEY_S_BIT],
                              step_in_use_ff, limit_in_use_ff);
      side_level_in = ramp({side_level_ff[kmrr_pkg::STICK_W-1], side_level_ff},
                           s1_data_ff.key_bits[kmrr_pkg::KEY_D_BIT],
                           s1_data_ff.key_bits[kmrr_pkg::KEY_A_BIT],
                           step_in_use_ff, limit_in_use_ff);
      rsp_data_in.forward_stick = forward_level_in[kmrr_pkg::STICK_W-1:0];
      rsp_data_in.side_stick = side_level_in[kmrr_pkg::STICK_W-1:0];
      rsp_data_in.aim_x = aim(s1_data_ff.mouse_dx, mouse_x_limit_ff, mouse_x_gain_ff);
      rsp_data_in.aim_y = aim(s1_data_ff.mouse_dy, mouse_y_limit_ff, mouse_y_gain_ff);

      // latch next frame's step and limit from this frame's shift key when keyboard_active is set
      step_in_use_in = step_in_use_ff;
      limit_in_use_in = limit_in_use_ff;
      if (s1_data_ff.keyboard_active) begin
         if (s1_data_ff.key_bits[kmrr_pkg::KEY_SHIFT_BIT]) begin
            step_in_use_in = fast_step_ff;
            limit_in_use_in = fast_limit_ff;
         end else begin
            step_in_use_in = slow_step_ff;
            limit_in_use_in = slow_limit_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         forward_level_ff <= '0;
         side_level_ff <= '0;
         step_in_use_ff <= kmrr_pkg::RST_STEP_IN_USE;
         limit_in_use_ff <= kmrr_pkg::RST_LIMIT_IN_USE;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_valid_ff && advance) begin
            forward_level_ff <= forward_level_in[kmrr_pkg::STICK_W-1:0];
            side_level_ff <= side_level_in[kmrr_pkg::STICK_W-1:0];
            step_in_use_ff <= step_in_use_in;
            limit_in_use_ff <= limit_in_use_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) s1_data_ff <= req_data;
      if (s1_valid_ff && advance) rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_step_ff <= kmrr_pkg::RST_FAST_STEP;
         fast_limit_ff <= kmrr_pkg::RST_FAST_LIMIT;
         slow_step_ff <= kmrr_pkg::RST_SLOW_STEP;
         slow_limit_ff <= kmrr_pkg::RST_SLOW_LIMIT;
         mouse_x_limit_ff <= kmrr_pkg::RST_MOUSE_LIMIT;
         mouse_y_limit_ff <= kmrr_pkg::RST_MOUSE_LIMIT;
         mouse_x_gain_ff <= kmrr_pkg::RST_MOUSE_GAIN;
         mouse_y_gain_ff <= kmrr_pkg::RST_MOUSE_GAIN;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            kmrr_pkg::REG_FAST_STEP:
               fast_step_ff <= csr_data[kmrr_pkg::STEP_W-1:0];
            kmrr_pkg::REG_FAST_LIMIT:
               fast_limit_ff <= csr_data[kmrr_pkg::LIMIT_W-1:0];
            kmrr_pkg::REG_SLOW_STEP:
               slow_step_ff <= csr_data[kmrr_pkg::STEP_W-1:0];
            kmrr_pkg::REG_SLOW_LIMIT:
               slow_limit_ff <= csr_data[kmrr_pkg::LIMIT_W-1:0];
            kmrr_pkg::REG_MOUSE_X_LIMIT:
               mouse_x_limit_ff <= csr_data[kmrr_pkg::MLIM_W-1:0];
            kmrr_pkg::REG_MOUSE_Y_LIMIT:
               mouse_y_limit_ff <= csr_data[kmrr_pkg::MLIM_W-1:0];
            kmrr_pkg::REG_MOUSE_X_GAIN:
               mouse_x_gain_ff <= csr_data[kmrr_pkg::GAIN_W-1:0];
            kmrr_pkg::REG_MOUSE_Y_GAIN:
               mouse_y_gain_ff <= csr_data[kmrr_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   a_forward_bound: assert property (@(posedge clock) disable iff (reset)
      forward_level_ff <= 12'sd1023 && forward_level_ff >= -12'sd1023)
      else $error("forward level outside +/-1023");

   a_side_bound: assert property (@(posedge clock) disable iff (reset)
      side_level_ff <= 12'sd1023 && side_level_ff >= -12'sd1023)
      else $error("side level outside +/-1023");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !(s1_valid_ff && advance) |=> $stable(forward_level_ff) && $stable(side_level_ff)
         && $stable(step_in_use_ff) && $stable(limit_in_use_ff))
      else $error("stick state changed without a frame advancing");

endmodule
